// ----- design/nlmb_pkg.sv -----
// Shared types, constants and helper functions for the notification LED controller.
package nlmb_pkg;

    localparam int LEVEL_W = 4;
    localparam int CAP_W   = 7;
    localparam int TIME_W  = 16;
    localparam int DRIVE_W = 8;
    localparam int MUL_W   = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 4'd9;
    localparam logic [CAP_W-1:0]   CAPACITY_MAX = 7'd100;
    localparam logic [TIME_W-1:0]  TIME_RESET   = 16'd500;
    localparam logic [MUL_W-1:0]   FULL_DRIVE   = 16'd255;
    localparam logic [6:0]         STEP_PERCENT = 7'd7;
    localparam logic [6:0]         CUT_MAX      = 7'd80;
    localparam logic [6:0]         PERCENT_HIGH = 7'd90;
    localparam logic [6:0]         PERCENT_LOW  = 7'd30;
    localparam logic [6:0]         PERCENT_FULL = 7'd100;

    // x / 100 == (x * 5243) >> 19 for x < 2^15; x / 9 == (x * 7282) >> 16 for x < 2^12
    localparam logic [MUL_W-1:0] RECIP_100 = 16'd5243;
    localparam logic [MUL_W-1:0] RECIP_9   = 16'd7282;

    localparam logic [1:0] MODE_DARK  = 2'd0;
    localparam logic [1:0] MODE_SOLID = 2'd1;
    localparam logic [1:0] MODE_DUAL  = 2'd2;

    localparam logic [1:0] KIND_LEVEL    = 2'd0;
    localparam logic [1:0] KIND_CAPACITY = 2'd1;
    localparam logic [1:0] KIND_OFF      = 2'd2;
    localparam logic [1:0] KIND_TICK     = 2'd3;

    localparam logic REG_ON_TIME  = 1'b0;
    localparam logic REG_OFF_TIME = 1'b1;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_16 = 2'd1;
    localparam logic [1:0] SH_19 = 2'd2;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
        logic [1:0]       shift;
    } mul_req_t;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

    function automatic logic [CAP_W-1:0] sat_cap(input logic [CAP_W-1:0] v);
        return (v > CAPACITY_MAX) ? CAPACITY_MAX : v;
    endfunction

    // capacity decile: 0 at 0, 1 for 1..10, ..., 9 for 81 and up
    function automatic logic [LEVEL_W-1:0] cap_decile(input logic [CAP_W-1:0] c);
        logic [LEVEL_W-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++) begin
            if (c > CAP_W'(k * 10)) d = LEVEL_W'(k + 1);
        end
        return d;
    endfunction

    function automatic logic [6:0] charge_percent(input logic [LEVEL_W-1:0] d);
        logic [6:0] p;
        if (d <= 4'd1) begin
            p = PERCENT_HIGH;
        end else begin
            p = PERCENT_FULL - 7'(d - 4'd1) * STEP_PERCENT;
            if (p > PERCENT_HIGH) p = PERCENT_HIGH;
            if (p < PERCENT_LOW) p = PERCENT_LOW;
        end
        return p;
    endfunction

    // percent of the base brightness kept after the low-charge reduction
    function automatic logic [6:0] charge_keep(input logic [LEVEL_W-1:0] d,
                                               input logic [LEVEL_W-1:0] chg);
        logic [6:0] cut;
        cut = '0;
        if (chg != '0 && chg < d) begin
            cut = 7'(d - chg) * 7'd10;
            if (cut > CUT_MAX) cut = CUT_MAX;
        end
        return PERCENT_FULL - cut;
    endfunction

endpackage

// ----- design/nlmb_mul.sv -----
// Shared registered multiplier with selectable output shift.
module nlmb_mul import nlmb_pkg::*; (
    input  logic             aclk,
    input  mul_req_t         req,
    output logic [MUL_W-1:0] res
);

    logic [2*MUL_W-1:0] prod;
    logic [MUL_W-1:0]   res_reg;
    logic [MUL_W-1:0]   res_next;

    assign prod = req.a * req.b;

    always_comb begin
        case (req.shift)
            SH_0:    res_next = prod[MUL_W-1:0];
            SH_16:   res_next = prod[2*MUL_W-1:MUL_W];
            SH_19:   res_next = {3'b000, prod[2*MUL_W-1:19]};
            default: res_next = prod[MUL_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- design/notify_led_mode_and_blink.sv -----
// Notification LED mode and blink controller, top level.
//
// Each request produces one result holding the LED brightness, mode and blink phase.
// Level updates, off commands and capacity updates that change the held capacity
// pass through the sequencer, which makes six passes through one shared 16x16
// registered multiplier (charge percent scaling, divide by 100, low-charge reduction,
// divide by 100, notification level scaling, divide by 9), applies the mode update
// and then loads the result register.
// Millisecond ticks and capacity updates that leave the held value unchanged skip the
// multiplier passes and go straight to the step that loads the result register.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register until taken, and the sequencer holds in its final step while that register
// is still occupied. Blink times are written through the cfg port at any time the
// block is idle.
module notify_led_mode_and_blink import nlmb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // call_level[3:0], sms_level[7:4], notice_level[11:8], charge_level[15:12],
    // capacity[22:16], zero pad[23]
    input  logic [23:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // brightness[7:0], mode[9:8], blink_phase[10], zero pad[15:11]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_E1   = 4'd1;
    localparam logic [3:0] ST_E2   = 4'd2;
    localparam logic [3:0] ST_E3   = 4'd3;
    localparam logic [3:0] ST_E4   = 4'd4;
    localparam logic [3:0] ST_E5   = 4'd5;
    localparam logic [3:0] ST_E6   = 4'd6;
    localparam logic [3:0] ST_E7   = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]         state_reg,    state_next;
    logic [LEVEL_W-1:0] call_reg,     call_next;
    logic [LEVEL_W-1:0] sms_reg,      sms_next;
    logic [LEVEL_W-1:0] notice_reg,   notice_next;
    logic [LEVEL_W-1:0] charge_reg,   charge_next;
    logic [CAP_W-1:0]   cap_reg,      cap_next;
    logic [1:0]         mode_reg,     mode_next;
    logic               phase_reg,    phase_next;
    logic [DRIVE_W-1:0] high_reg,     high_next;
    logic [DRIVE_W-1:0] low_reg,      low_next;
    logic [TIME_W-1:0]  count_reg,    count_next;
    logic [DRIVE_W-1:0] drive_reg,    drive_next;
    logic [TIME_W-1:0]  on_time_reg,  on_time_next;
    logic [TIME_W-1:0]  off_time_reg, off_time_next;
    logic [DRIVE_W-1:0] cb_reg,       cb_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg,  m_tdata_next;

    mul_req_t           mreq;
    logic [MUL_W-1:0]   mres;
    logic               s_accept;
    logic [LEVEL_W-1:0] decile;
    logic [LEVEL_W-1:0] pick;
    logic [CAP_W-1:0]   cap_in;
    logic [TIME_W-1:0]  on_load;
    logic [TIME_W-1:0]  off_load;

    nlmb_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .res  (mres)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign decile   = cap_decile(cap_reg);
    assign cap_in   = sat_cap(s_tdata[22:16]);
    assign on_load  = (on_time_reg == '0) ? TIME_W'(1) : on_time_reg;
    assign off_load = (off_time_reg == '0) ? TIME_W'(1) : off_time_reg;

    always_comb begin
        if (call_reg != '0)        pick = call_reg;
        else if (sms_reg != '0)    pick = sms_reg;
        else                       pick = notice_reg;
    end

    always_comb begin
        state_next    = state_reg;
        call_next     = call_reg;
        sms_next      = sms_reg;
        notice_next   = notice_reg;
        charge_next   = charge_reg;
        cap_next      = cap_reg;
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        count_next    = count_reg;
        drive_next    = drive_reg;
        on_time_next  = on_time_reg;
        off_time_next = off_time_reg;
        cb_next       = cb_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mreq          = '{a: '0, b: '0, shift: SH_0};

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        if (cfg_valid) begin
            if (cfg_index == REG_ON_TIME) on_time_next = cfg_data;
            else                          off_time_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        KIND_LEVEL: begin
                            call_next   = sat_level(s_tdata[3:0]);
                            sms_next    = sat_level(s_tdata[7:4]);
                            notice_next = sat_level(s_tdata[11:8]);
                            charge_next = sat_level(s_tdata[15:12]);
                            state_next  = ST_E1;
                        end
                        KIND_CAPACITY: begin
                            if (cap_in != cap_reg) begin
                                cap_next   = cap_in;
                                state_next = ST_E1;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        KIND_OFF: begin
                            call_next   = '0;
                            sms_next    = '0;
                            notice_next = '0;
                            charge_next = '0;
                            state_next  = ST_E1;
                        end
                        default: begin
                            if (mode_reg == MODE_DUAL) begin
                                if (count_reg > TIME_W'(1)) begin
                                    count_next = count_reg - TIME_W'(1);
                                end else if (!phase_reg) begin
                                    phase_next = 1'b1;
                                    drive_next = low_reg;
                                    count_next = off_load;
                                end else begin
                                    phase_next = 1'b0;
                                    drive_next = high_reg;
                                    count_next = on_load;
                                end
                            end
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_E1: begin
                mreq       = '{a: MUL_W'(charge_percent(decile)), b: FULL_DRIVE, shift: SH_0};
                state_next = ST_E2;
            end
            ST_E2: begin
                mreq       = '{a: mres, b: RECIP_100, shift: SH_19};
                state_next = ST_E3;
            end
            ST_E3: begin
                mreq = '{a: mres, b: MUL_W'(charge_keep(decile, charge_reg)), shift: SH_0};
                state_next = ST_E4;
            end
            ST_E4: begin
                mreq       = '{a: mres, b: RECIP_100, shift: SH_19};
                state_next = ST_E5;
            end
            ST_E5: begin
                cb_next    = mres[DRIVE_W-1:0];
                mreq       = '{a: MUL_W'(pick), b: FULL_DRIVE, shift: SH_0};
                state_next = ST_E6;
            end
            ST_E6: begin
                mreq       = '{a: mres, b: RECIP_9, shift: SH_16};
                state_next = ST_E7;
            end
            ST_E7: begin
                phase_next = 1'b0;
                if (pick != '0) begin
                    high_next  = mres[DRIVE_W-1:0];
                    low_next   = (charge_reg != '0) ? cb_reg : '0;
                    mode_next  = MODE_DUAL;
                    drive_next = mres[DRIVE_W-1:0];
                    count_next = on_load;
                end else if (charge_reg != '0) begin
                    mode_next  = MODE_SOLID;
                    drive_next = cb_reg;
                    count_next = '0;
                end else begin
                    mode_next  = MODE_DARK;
                    drive_next = '0;
                    count_next = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b00000, phase_reg, mode_reg, drive_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            call_reg     <= '0;
            sms_reg      <= '0;
            notice_reg   <= '0;
            charge_reg   <= '0;
            cap_reg      <= CAPACITY_MAX;
            mode_reg     <= MODE_DARK;
            phase_reg    <= 1'b0;
            high_reg     <= '0;
            low_reg      <= '0;
            count_reg    <= '0;
            drive_reg    <= '0;
            on_time_reg  <= TIME_RESET;
            off_time_reg <= TIME_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            call_reg     <= call_next;
            sms_reg      <= sms_next;
            notice_reg   <= notice_next;
            charge_reg   <= charge_next;
            cap_reg      <= cap_next;
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            count_reg    <= count_next;
            drive_reg    <= drive_next;
            on_time_reg  <= on_time_next;
            off_time_reg <= off_time_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cb_reg      <= cb_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_phase_only_dual: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (mode_reg == MODE_DUAL))
        else $error("blink phase set outside dual blink");

    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_DUAL) |-> (count_reg != '0))
        else $error("dual blink with empty countdown");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_DARK) |-> (drive_reg == '0))
        else $error("LED driven while off");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request taken while previous request in flight");

endmodule
